/* rtl/pcs_pkg.sv */
// Shared widths, constants and types of the PUCT child selection block.
`timescale 1ns / 1ps

package pcs_pkg;

	localparam int VISITS_W   = 20;
	localparam int VSUM_W     = 33;
	localparam int PRIOR_W    = 16;
	localparam int PARENT_W   = 20;
	localparam int WEIGHT_W   = 16;
	localparam int SCORE_W    = 32;
	localparam int INDEX_W    = 8;

	localparam logic [WEIGHT_W-1:0] WEIGHT_RESET = 16'd5734;

	// Iterative unit widths: dividend covers |value_sum * 16|, divisor is visits + 1
	localparam int DIVIDEND_W = 37;
	localparam int DIVISOR_W  = 21;
	localparam int ROOT_W     = 26;
	localparam int REM_W      = 30;
	localparam int STEP_W     = 6;
	localparam int DIV_STEPS  = 37;
	localparam int SQRT_STEPS = 26;

	// Exploration term: c * prior (Q.28) times root (Q.16), scaled down by 2^28
	localparam int PROD_W     = WEIGHT_W + PRIOR_W;
	localparam int NUM_W      = PROD_W + ROOT_W;
	localparam int EXPL_SHIFT = 28;
	localparam int EXPL_W     = NUM_W - EXPL_SHIFT;
	localparam int MEAN_W     = DIVIDEND_W + 1;
	localparam int SUM_W      = MEAN_W + 1;

	typedef struct packed {
		logic start;
		logic sqrt_mode;
	} unit_cmd_t;

endpackage

/* rtl/pcs_ifs.sv */
// Handshake channels for child statistics and selection results.
`timescale 1ns / 1ps

interface pcs_child_if;
	logic                                  valid;
	logic                                  ready;
	logic        [pcs_pkg::VISITS_W-1:0]   child_visit_count;
	logic signed [pcs_pkg::VSUM_W-1:0]     child_value_sum;
	logic        [pcs_pkg::PRIOR_W-1:0]    child_prior;
	logic        [pcs_pkg::PARENT_W-1:0]   parent_visit_count;
	logic                                  child_present;
	logic                                  last_child;

	modport source (
		output valid, child_visit_count, child_value_sum, child_prior, parent_visit_count,
			child_present, last_child,
		input  ready
	);
	modport sink (
		input  valid, child_visit_count, child_value_sum, child_prior, parent_visit_count,
			child_present, last_child,
		output ready
	);
endinterface

interface pcs_result_if;
	logic                                  valid;
	logic                                  ready;
	logic        [pcs_pkg::INDEX_W-1:0]    best_index;
	logic                                  found;
	logic                                  chose_unvisited;
	logic signed [pcs_pkg::SCORE_W-1:0]    best_score;

	modport source (
		output valid, best_index, found, chose_unvisited, best_score,
		input  ready
	);
	modport sink (
		input  valid, best_index, found, chose_unvisited, best_score,
		output ready
	);
endinterface

/* rtl/puct_child_select.sv */
// Top level of the PUCT child selection block: sequencer, multiplier and run state.
//
// Usage: feed one child per transaction on the child channel; mark the final child of
// a node with last_child. After the final child one transaction on the result channel
// carries the chosen position, found and chose_unvisited flags and the Q15.16 score.
// cfg_we / cfg_wdata write the exploration constant (Q4.12); the user must write it only
// while the block is idle, which the block itself leaves unenforced.
// Scoring: mean = value_sum*16/visits, plus c*prior*sqrt(parent)/(1+visits), saturated.
// Child flow: the child channel is ready only in idle, one child at a time. An absent,
// locked-out or unvisited child goes from S_CHK to S_POST and back to idle; a scored
// child passes S_MUL1, S_MUL2, two 37-step divides on the shared unit (each waited out
// until its done flag), S_SUM, S_UPD and S_POST. The first child of a run, and each wrap
// of the position counter, first runs the 26-step square root of the parent count.
// A final child goes on from S_POST to S_FIN, which loads the result register and
// raises valid once the register is free. A finished result waits in its output
// register while the next run is taken in; if the receiver stalls, the block waits on
// the final child of the next run and takes no new child until the register is free.
// Reset (arst_n low) clears run state and output valid; exploration constant = 5734.
`timescale 1ns / 1ps

module puct_child_select #(
	parameter int MAX_CHILDREN = 256
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [pcs_pkg::WEIGHT_W-1:0]  cfg_wdata,
	pcs_child_if.sink                     child,
	pcs_result_if.source                  result
);

	localparam int CW = (MAX_CHILDREN > 1) ? $clog2(MAX_CHILDREN) : 1;

	localparam logic [3:0] S_IDLE    = 4'd0;
	localparam logic [3:0] S_SQ_GO   = 4'd1;
	localparam logic [3:0] S_SQ_WAIT = 4'd2;
	localparam logic [3:0] S_CHK     = 4'd3;
	localparam logic [3:0] S_MUL1    = 4'd4;
	localparam logic [3:0] S_MUL2    = 4'd5;
	localparam logic [3:0] S_DM_WAIT = 4'd6;
	localparam logic [3:0] S_DE_GO   = 4'd7;
	localparam logic [3:0] S_DE_WAIT = 4'd8;
	localparam logic [3:0] S_SUM     = 4'd9;
	localparam logic [3:0] S_UPD     = 4'd10;
	localparam logic [3:0] S_POST    = 4'd11;
	localparam logic [3:0] S_FIN     = 4'd12;

	logic [3:0]                          state_q;
	logic [pcs_pkg::WEIGHT_W-1:0]        weight_q;

	// Latched child item
	logic [pcs_pkg::VISITS_W-1:0]        visits_q;
	logic signed [pcs_pkg::VSUM_W-1:0]   vsum_q;
	logic [pcs_pkg::PRIOR_W-1:0]         prior_q;
	logic [pcs_pkg::PARENT_W-1:0]        parent_q;
	logic                                present_q;
	logic                                last_q;

	// Run state
	logic signed [pcs_pkg::SCORE_W-1:0]  best_q;
	logic [CW-1:0]                       idx_q;
	logic [CW-1:0]                       cnt_q;
	logic                                have_q;
	logic                                locked_q;
	logic [pcs_pkg::ROOT_W-1:0]          root_q;

	// Score datapath
	logic [pcs_pkg::PROD_W-1:0]          prod_q;
	logic [pcs_pkg::EXPL_W-1:0]          expl_num_q;
	logic [pcs_pkg::EXPL_W-1:0]          expl_q;
	logic signed [pcs_pkg::MEAN_W-1:0]   mean_q;
	logic                                neg_q;
	logic signed [pcs_pkg::SCORE_W-1:0]  score_q;

	// Result register
	logic                                out_valid_q;
	logic [pcs_pkg::INDEX_W-1:0]         out_index_q;
	logic                                out_found_q;
	logic                                out_unv_q;
	logic signed [pcs_pkg::SCORE_W-1:0]  out_score_q;

	// Shared unit hookup
	pcs_pkg::unit_cmd_t                  cmd;
	logic [pcs_pkg::DIVIDEND_W-1:0]      opa;
	logic [pcs_pkg::DIVISOR_W-1:0]       opb;
	logic                                unit_done;
	logic [pcs_pkg::DIVIDEND_W-1:0]      unit_res;

	logic signed [pcs_pkg::MEAN_W-1:0]   scaled;
	logic [pcs_pkg::MEAN_W-1:0]          mag;
	logic [pcs_pkg::NUM_W-1:0]           num_c;
	logic [pcs_pkg::PROD_W-1:0]          prod_c;
	logic signed [pcs_pkg::SUM_W-1:0]    sum_c;
	logic signed [pcs_pkg::SCORE_W-1:0]  sat_c;
	logic                                accept;
	logic                                out_free;

	assign accept   = child.valid && child.ready;
	assign out_free = !out_valid_q || result.ready;
	assign child.ready = (state_q == S_IDLE);

	// Magnitude of value_sum * 16 for the unsigned divide
	always_comb begin
		scaled = {vsum_q[pcs_pkg::VSUM_W-1], vsum_q, 4'b0000};
		mag    = scaled[pcs_pkg::MEAN_W-1] ? pcs_pkg::MEAN_W'(-scaled)
			: pcs_pkg::MEAN_W'(scaled);
	end

	// Products for the exploration term
	assign prod_c = weight_q * prior_q;
	assign num_c  = prod_q * root_q;

	// Add mean and exploration, clamp to signed 32 bits
	always_comb begin
		sum_c = {mean_q[pcs_pkg::MEAN_W-1], mean_q}
			+ $signed({{(pcs_pkg::SUM_W-pcs_pkg::EXPL_W){1'b0}}, expl_q});
		if (sum_c[pcs_pkg::SUM_W-1:pcs_pkg::SCORE_W-1] == '0
			|| sum_c[pcs_pkg::SUM_W-1:pcs_pkg::SCORE_W-1] == '1) begin
			sat_c = sum_c[pcs_pkg::SCORE_W-1:0];
		end else if (sum_c[pcs_pkg::SUM_W-1]) begin
			sat_c = {1'b1, {(pcs_pkg::SCORE_W-1){1'b0}}};
		end else begin
			sat_c = {1'b0, {(pcs_pkg::SCORE_W-1){1'b1}}};
		end
	end

	// Issue commands to the shared unit
	always_comb begin
		cmd.start     = 1'b0;
		cmd.sqrt_mode = 1'b0;
		opa           = mag[pcs_pkg::DIVIDEND_W-1:0];
		opb           = {1'b0, visits_q};
		case (state_q)
			S_SQ_GO: begin
				cmd.start     = 1'b1;
				cmd.sqrt_mode = 1'b1;
				opa = {parent_q, {(pcs_pkg::DIVIDEND_W-pcs_pkg::PARENT_W){1'b0}}};
			end
			S_MUL1: begin
				cmd.start = 1'b1;
			end
			S_DE_GO: begin
				cmd.start = 1'b1;
				opa = pcs_pkg::DIVIDEND_W'(expl_num_q);
				opb = {1'b0, visits_q} + pcs_pkg::DIVISOR_W'(1);
			end
			default: begin
				cmd.start = 1'b0;
			end
		endcase
	end

	pcs_iter_unit u_unit (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.opa    (opa),
		.opb    (opb),
		.done   (unit_done),
		.result (unit_res)
	);

	// Hold the exploration constant
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			weight_q <= pcs_pkg::WEIGHT_RESET;
		end else if (cfg_we) begin
			weight_q <= cfg_wdata;
		end
	end

	// Latch the incoming child
	always_ff @(posedge clk) begin
		if (accept) begin
			visits_q  <= child.child_visit_count;
			vsum_q    <= child.child_value_sum;
			prior_q   <= child.child_prior;
			parent_q  <= child.parent_visit_count;
			present_q <= child.child_present;
			last_q    <= child.last_child;
		end
	end

	// Score datapath registers
	always_ff @(posedge clk) begin
		if (state_q == S_MUL1) begin
			prod_q <= prod_c;
			neg_q  <= vsum_q[pcs_pkg::VSUM_W-1];
		end
		if (state_q == S_MUL2) begin
			expl_num_q <= num_c[pcs_pkg::NUM_W-1:pcs_pkg::EXPL_SHIFT];
		end
		if (state_q == S_DM_WAIT && unit_done) begin
			mean_q <= neg_q ? -$signed({1'b0, unit_res}) : $signed({1'b0, unit_res});
		end
		if (state_q == S_DE_WAIT && unit_done) begin
			expl_q <= unit_res[pcs_pkg::EXPL_W-1:0];
		end
		if (state_q == S_SUM) begin
			score_q <= sat_c;
		end
		if (state_q == S_SQ_WAIT && unit_done) begin
			root_q <= unit_res[pcs_pkg::ROOT_W-1:0];
		end
	end

	// Result payload
	always_ff @(posedge clk) begin
		if (state_q == S_FIN && out_free) begin
			out_index_q <= have_q ? pcs_pkg::INDEX_W'(idx_q) : '0;
			out_found_q <= have_q;
			out_unv_q   <= locked_q;
			out_score_q <= (have_q && !locked_q) ? best_q : '0;
		end
	end

	// Sequencer and run state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			best_q      <= {1'b1, {(pcs_pkg::SCORE_W-1){1'b0}}};
			idx_q       <= '0;
			cnt_q       <= '0;
			have_q      <= 1'b0;
			locked_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			// Raise valid on a loaded result, drop it once the transaction is taken
			if (state_q == S_FIN && out_free) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q <= (cnt_q == '0) ? S_SQ_GO : S_CHK;
					end
				end
				S_SQ_GO: begin
					state_q <= S_SQ_WAIT;
				end
				S_SQ_WAIT: begin
					if (unit_done) begin
						state_q <= S_CHK;
					end
				end
				S_CHK: begin
					if (present_q && !locked_q) begin
						if (visits_q == '0) begin
							locked_q <= 1'b1;
							have_q   <= 1'b1;
							idx_q    <= cnt_q;
							best_q   <= '0;
							state_q  <= S_POST;
						end else begin
							state_q <= S_MUL1;
						end
					end else begin
						state_q <= S_POST;
					end
				end
				S_MUL1: begin
					state_q <= S_MUL2;
				end
				S_MUL2: begin
					state_q <= S_DM_WAIT;
				end
				S_DM_WAIT: begin
					if (unit_done) begin
						state_q <= S_DE_GO;
					end
				end
				S_DE_GO: begin
					state_q <= S_DE_WAIT;
				end
				S_DE_WAIT: begin
					if (unit_done) begin
						state_q <= S_SUM;
					end
				end
				S_SUM: begin
					state_q <= S_UPD;
				end
				S_UPD: begin
					if (!have_q || score_q > best_q) begin
						have_q <= 1'b1;
						idx_q  <= cnt_q;
						best_q <= score_q;
					end
					state_q <= S_POST;
				end
				S_POST: begin
					cnt_q   <= (cnt_q == CW'(MAX_CHILDREN - 1)) ? '0 : cnt_q + 1'b1;
					state_q <= last_q ? S_FIN : S_IDLE;
				end
				S_FIN: begin
					if (out_free) begin
						best_q      <= {1'b1, {(pcs_pkg::SCORE_W-1){1'b0}}};
						idx_q       <= '0;
						cnt_q       <= '0;
						have_q      <= 1'b0;
						locked_q    <= 1'b0;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign result.valid           = out_valid_q;
	assign result.best_index      = out_index_q;
	assign result.found           = out_found_q;
	assign result.chose_unvisited = out_unv_q;
	assign result.best_score      = out_score_q;

endmodule

/* rtl/pcs_iter_unit.sv */
// Shared iterative unit: restoring divide or digit-by-digit square root, one bit per cycle.
`timescale 1ns / 1ps

module pcs_iter_unit (
	input  logic                               clk,
	input  logic                               arst_n,
	input  pcs_pkg::unit_cmd_t                 cmd,
	input  logic [pcs_pkg::DIVIDEND_W-1:0]     opa,
	input  logic [pcs_pkg::DIVISOR_W-1:0]      opb,
	output logic                               done,
	output logic [pcs_pkg::DIVIDEND_W-1:0]     result
);

	logic [pcs_pkg::REM_W-1:0]      rem_q;
	logic [pcs_pkg::DIVIDEND_W-1:0] quo_q;
	logic [pcs_pkg::ROOT_W-1:0]     res_q;
	logic [pcs_pkg::DIVISOR_W-1:0]  div_q;
	logic [pcs_pkg::STEP_W-1:0]     cnt_q;
	logic                           busy_q;
	logic                           sqrt_q;
	logic                           done_q;

	logic [pcs_pkg::REM_W-1:0]      a;
	logic [pcs_pkg::REM_W-1:0]      b;
	logic [pcs_pkg::REM_W:0]        diff;
	logic                           ge;

	// Form the trial operands and run the one shared subtractor
	always_comb begin
		if (sqrt_q) begin
			a = {rem_q[pcs_pkg::REM_W-3:0], quo_q[pcs_pkg::DIVIDEND_W-1 -: 2]};
			b = {{(pcs_pkg::REM_W-pcs_pkg::ROOT_W-2){1'b0}}, res_q, 2'b01};
		end else begin
			a = {rem_q[pcs_pkg::REM_W-2:0], quo_q[pcs_pkg::DIVIDEND_W-1]};
			b = {{(pcs_pkg::REM_W-pcs_pkg::DIVISOR_W){1'b0}}, div_q};
		end
		diff = {1'b0, a} - {1'b0, b};
		ge   = ~diff[pcs_pkg::REM_W];
	end

	// Control: load on start, count down one step per cycle, flag the last step
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
			sqrt_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (cmd.start) begin
				busy_q <= 1'b1;
				sqrt_q <= cmd.sqrt_mode;
				cnt_q  <= cmd.sqrt_mode ? pcs_pkg::STEP_W'(pcs_pkg::SQRT_STEPS)
					: pcs_pkg::STEP_W'(pcs_pkg::DIV_STEPS);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == pcs_pkg::STEP_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Datapath: shift operand bits in, shift quotient or root bits out
	always_ff @(posedge clk) begin
		if (cmd.start) begin
			rem_q <= '0;
			quo_q <= opa;
			res_q <= '0;
			div_q <= opb;
		end else if (busy_q) begin
			rem_q <= ge ? diff[pcs_pkg::REM_W-1:0] : a;
			if (sqrt_q) begin
				quo_q <= {quo_q[pcs_pkg::DIVIDEND_W-3:0], 2'b00};
				res_q <= {res_q[pcs_pkg::ROOT_W-2:0], ge};
			end else begin
				quo_q <= {quo_q[pcs_pkg::DIVIDEND_W-2:0], ge};
			end
		end
	end

	assign done   = done_q;
	assign result = sqrt_q ? pcs_pkg::DIVIDEND_W'(res_q) : quo_q;

endmodule
